>>> design/gcr_pkg.sv
// ----------------------------------------------------------------------------
// gcr_pkg
// Types, constants and the 5-to-4 code table for the GCR track deframer.
// ----------------------------------------------------------------------------
package gcr_pkg;

    localparam int unsigned GROUP_W    = 7;
    localparam int unsigned BLK_CNT_W  = 10;
    localparam int unsigned IDX_W      = 9;
    localparam int unsigned BIT_CNT_W  = 4;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [GROUP_W-1:0] HEADER_GROUPS_RST = 7'd2;
    localparam logic [GROUP_W-1:0] DATA_GROUPS_RST   = 7'd65;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam logic [7:0] BAD_CODE  = 8'hFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_GROUPS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_GROUPS   = 1'b1;

    typedef enum logic [2:0] {
        MODE_HSYNC = 3'd0,
        MODE_HBLK  = 3'd1,
        MODE_HGAP  = 3'd2,
        MODE_DSYNC = 3'd3,
        MODE_DBLK  = 3'd4,
        MODE_DGAP  = 3'd5
    } t_gcr_mode;

    typedef struct packed {
        logic [7:0] raw_byte;
        logic       track_end;
    } t_gcr_in;

    typedef struct packed {
        logic [7:0]       decoded_byte;
        logic             in_data_block;
        logic [IDX_W-1:0] byte_index;
        logic             block_last;
        logic             code_error;
    } t_gcr_out;

    // 5-bit gcr code to nibble, BAD_CODE for codes that are not used
    function automatic logic [7:0] gcr_nibble(input logic [4:0] code);
        logic [7:0] nib;
        begin
            case (code)
                5'h09: nib = 8'h08;
                5'h0A: nib = 8'h00;
                5'h0B: nib = 8'h01;
                5'h0D: nib = 8'h0C;
                5'h0E: nib = 8'h04;
                5'h0F: nib = 8'h05;
                5'h12: nib = 8'h02;
                5'h13: nib = 8'h03;
                5'h15: nib = 8'h0F;
                5'h16: nib = 8'h06;
                5'h17: nib = 8'h07;
                5'h19: nib = 8'h09;
                5'h1A: nib = 8'h0A;
                5'h1B: nib = 8'h0B;
                5'h1D: nib = 8'h0D;
                5'h1E: nib = 8'h0E;
                default: nib = BAD_CODE;
            endcase
            return nib;
        end
    endfunction

endpackage

>>> design/gcr_track_deframe_decode_core.sv
// ----------------------------------------------------------------------------
// gcr_track_deframe_decode_core
// Deframes a raw GCR track byte stream and decodes header and data blocks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_stall / i_in carries one raw track word
//   (raw_byte plus a track_end mark). Output channel o_out_valid / i_out_stall
//   / o_out carries one decoded byte with its block flags and index.
//   Config: pulse i_cfg_we with i_cfg_idx / i_cfg_data while the block is
//   idle to set header and data block lengths in 5-byte groups.
// Timing:
//   one input word per cycle while o_in_stall is low. A decoded byte goes
//   to o_out through the result register, or the skid register on a stall.
//   Decode is a single registered pass: mode and bit buffer update and table
//   lookup all happen between the input handshake and the result register.
// Stall:
//   a result register plus a one-word skid register sit on the output; the
//   input is stalled only while the skid register holds a word, so a stalled
//   receiver costs at most one extra buffered result.
// Reset:
//   synchronous, active low; returns to header sync, clears counters and the
//   bit buffer, and loads the default block lengths (10 and 325 bytes).
// ----------------------------------------------------------------------------
module gcr_track_deframe_decode_core
    import gcr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_gcr_in              i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_gcr_out             o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [GROUP_W-1:0]   i_cfg_data
);

    logic [GROUP_W-1:0]   r_header_groups;
    logic [GROUP_W-1:0]   r_data_groups;
    t_gcr_mode            r_mode, n_mode;
    logic [BLK_CNT_W-1:0] r_blk_cnt, n_blk_cnt;
    logic [7:0]           r_bit_buf, n_bit_buf;
    logic [BIT_CNT_W-1:0] r_bit_cnt, n_bit_cnt;
    logic [IDX_W-1:0]     r_out_cnt, n_out_cnt;
    logic                 r_out_v;
    t_gcr_out             r_out;
    logic                 r_skid_v;
    t_gcr_out             r_skid;

    logic                 accept;
    logic                 in_blk;
    logic                 is_sync;
    logic                 is_data;
    logic                 blk_end;
    logic                 produce;
    logic [BLK_CNT_W-1:0] base_blk_cnt;
    logic [7:0]           base_bit_buf;
    logic [BIT_CNT_W-1:0] base_bit_cnt;
    logic [IDX_W-1:0]     base_out_cnt;
    logic [BLK_CNT_W-1:0] blk_len;
    logic [GROUP_W-1:0]   groups;
    logic [15:0]          buf16;
    logic [BIT_CNT_W:0]   cnt_sum;
    logic [BIT_CNT_W:0]   shamt;
    logic [15:0]          shifted;
    logic [9:0]           pair;
    logic [7:0]           hi_nib;
    logic [7:0]           lo_nib;
    logic [7:0]           keep_mask;
    logic                 res_v;
    t_gcr_out             res;
    logic                 out_free;

    assign accept      = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_skid_v;
    assign o_out_valid = r_out_v;
    assign o_out       = r_out;
    assign out_free    = !r_out_v || !i_out_stall;

    // block byte datapath
    always_comb begin
        is_sync = (r_mode == MODE_HSYNC) || (r_mode == MODE_DSYNC);
        is_data = (r_mode == MODE_DSYNC) || (r_mode == MODE_DBLK);
        in_blk  = (r_mode == MODE_HBLK) || (r_mode == MODE_DBLK) ||
                  (is_sync && (i_in.raw_byte != SYNC_BYTE));

        // entering a block from sync starts from a clean buffer
        base_blk_cnt = is_sync ? '0 : r_blk_cnt;
        base_bit_buf = is_sync ? '0 : r_bit_buf;
        base_bit_cnt = is_sync ? '0 : r_bit_cnt;
        base_out_cnt = is_sync ? '0 : r_out_cnt;

        groups  = is_data ? r_data_groups : r_header_groups;
        blk_len = {1'b0, groups, 2'b00} + {3'b000, groups};

        buf16   = {base_bit_buf, i_in.raw_byte};
        cnt_sum = {1'b0, base_bit_cnt} + (BIT_CNT_W+1)'(8);
        produce = (cnt_sum >= (BIT_CNT_W+1)'(10));
        shamt   = cnt_sum - (BIT_CNT_W+1)'(10);
        shifted = buf16 >> shamt;
        pair    = shifted[9:0];
        hi_nib  = gcr_nibble(pair[9:5]);
        lo_nib  = gcr_nibble(pair[4:0]);
        keep_mask = (8'd1 << shamt) - 8'd1;

        n_blk_cnt = base_blk_cnt + BLK_CNT_W'(1);
        blk_end   = in_blk && (n_blk_cnt >= blk_len);

        res_v              = in_blk && produce;
        res.decoded_byte   = {hi_nib[3:0], 4'h0} | lo_nib;
        res.in_data_block  = is_data;
        res.byte_index     = base_out_cnt;
        res.block_last     = blk_end;
        res.code_error     = (hi_nib == BAD_CODE) || (lo_nib == BAD_CODE);

        if (produce) begin
            n_bit_buf = buf16[7:0] & keep_mask;
            n_bit_cnt = shamt[BIT_CNT_W-1:0];
            n_out_cnt = base_out_cnt + IDX_W'(1);
        end else begin
            n_bit_buf = buf16[7:0];
            n_bit_cnt = cnt_sum[BIT_CNT_W-1:0];
            n_out_cnt = base_out_cnt;
        end
    end

    // mode sequencing
    always_comb begin
        case (r_mode)
            MODE_HSYNC: n_mode = in_blk ? MODE_HBLK : MODE_HSYNC;
            MODE_DSYNC: n_mode = in_blk ? MODE_DBLK : MODE_DSYNC;
            MODE_HBLK:  n_mode = MODE_HBLK;
            MODE_DBLK:  n_mode = MODE_DBLK;
            MODE_HGAP:  n_mode = (i_in.raw_byte == SYNC_BYTE) ? MODE_DSYNC : MODE_HGAP;
            MODE_DGAP:  n_mode = (i_in.raw_byte == SYNC_BYTE) ? MODE_HSYNC : MODE_DGAP;
            default:    n_mode = MODE_HSYNC;
        endcase
        if (blk_end) begin
            n_mode = is_data ? MODE_DGAP : MODE_HGAP;
        end
        if (i_in.track_end) begin
            n_mode = MODE_HSYNC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_groups <= HEADER_GROUPS_RST;
            r_data_groups   <= DATA_GROUPS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HEADER_GROUPS: r_header_groups <= i_cfg_data;
                CFG_DATA_GROUPS:   r_data_groups   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_HSYNC;
            r_blk_cnt <= '0;
            r_bit_buf <= '0;
            r_bit_cnt <= '0;
            r_out_cnt <= '0;
        end else if (accept) begin
            r_mode <= n_mode;
            if (blk_end || i_in.track_end || !in_blk) begin
                // gaps and syncs leave counters at zero
                r_blk_cnt <= '0;
                r_bit_buf <= '0;
                r_bit_cnt <= '0;
                r_out_cnt <= '0;
            end else begin
                r_blk_cnt <= n_blk_cnt;
                r_bit_buf <= n_bit_buf;
                r_bit_cnt <= n_bit_cnt;
                r_out_cnt <= n_out_cnt;
            end
        end
    end

    // result register with one-word skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= accept && res_v;
            end
        end else if (accept && res_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_v ? r_skid : res;
        end else if (accept && res_v) begin
            r_skid <= res;
        end
    end

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid word held with empty result register");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && i_out_stall))
        else $error("skid filled while result register was free");

    a_bit_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bit_cnt[0] == 1'b0) && (r_bit_cnt <= BIT_CNT_W'(8)))
        else $error("bit count out of range");

    a_sync_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_HSYNC || r_mode == MODE_DSYNC || r_mode == MODE_HGAP ||
         r_mode == MODE_DGAP) |-> (r_blk_cnt == '0 && r_bit_cnt == '0 && r_out_cnt == '0))
        else $error("block counters not cleared outside a block");
`endif

endmodule
